// ===== hdl/sha256_stream_hash_compare_unit_defines.svh =====
// Assertion macros for the SHA-256 stream hash compare unit
`ifndef SHA256_STREAM_HASH_COMPARE_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASH_COMPARE_UNIT_DEFINES_SVH

// Assert that an antecedent always implies a consequent in the next cycle.
`define SHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Assert that an expression holds in the same cycle.
`define SHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/shc_pkg.sv =====
// Package: shared types, constants and round functions for the SHA-256 compare unit
package shc_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = 2;

    typedef enum logic [1:0] {
        REG_EXP_W0 = 2'd0,
        REG_EXP_W1 = 2'd1,
        REG_EXP_W2 = 2'd2,
        REG_EXP_W3 = 2'd3
    } reg_idx_t;

    // Queue entry: a byte and its last flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } q_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } bk_state_t;

    typedef logic [31:0] word_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/shc_front.sv =====
// Front end: input beat intake and a short byte queue towards the compression engine
module shc_front
    import shc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output q_item_t    q_item,
    output logic       q_valid,
    input  logic       q_pop
);

    q_item_t        mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]   count_reg;
    logic           push;

    assign in_ready = (count_reg < (QAw+1)'(QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data: data_byte, last: final_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QAw+1)'(push) - (QAw+1)'(q_pop);
        end
    end

endmodule

// ===== hdl/shc_engine.sv =====
// Back end: block buffer, padding, 64-round compression and digest output
module shc_engine
    import shc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_item_t      q_item,
    input  logic         q_valid,
    output logic         q_pop,
    input  logic [255:0] expected,
    output logic [31:0]  digest_word,
    output logic [2:0]   word_index,
    output logic         run_end,
    output logic         digest_match,
    output logic         out_valid,
    input  logic         out_ready
);

    // 64-byte block buffer; written one byte at a time.
    logic [7:0]  buf_mem [64];
    word_t       w_reg [16];
    word_t       h_reg [8];
    word_t       v_reg [8];
    bk_state_t   state_reg, state_next;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  ld_reg;
    logic        final_reg;    // current block is the last of the message
    logic        second_reg;   // length still to go in a further block
    logic        mark_reg;     // 0x80 marker not yet written
    logic [63:0] total_reg;
    logic [2:0]  oidx_reg;
    logic        match_reg;
    logic        ovalid_reg;
    word_t       oword_reg;

    logic        buf_we;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic [7:0]  buf_rd_reg;
    word_t       t1, t2, wnew, s0, s1;

    always_comb
    begin
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1   = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
        t2   = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Pad byte at the fill point: the marker first, then zeros, the length in the last block.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        buf_we     = 1'b0;
        buf_wa     = fill_reg;
        buf_wd     = q_item.data;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    buf_we = 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (q_item.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                buf_we = 1'b1;
                buf_wa = fill_reg;
                if (mark_reg)
                begin
                    buf_wd = 8'h80;
                end
                else if (fill_reg >= 6'd56 && !second_reg)
                begin
                    buf_wd = total_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    buf_wd = 8'h00;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_reg == 6'd0 && rnd_reg == 6'd1)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready && oidx_reg == 3'd7 && ovalid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_wa] <= buf_wd;
        end
        buf_rd_reg <= buf_mem[ld_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            rnd_reg    <= '0;
            ld_reg     <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            mark_reg   <= 1'b0;
            total_reg  <= '0;
            oidx_reg   <= '0;
            match_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            oword_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
                v_reg[i] <= INIT_H[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        ld_reg   <= '0;
                        rnd_reg  <= '0;
                        if (fill_reg == 6'd63)
                        begin
                            final_reg  <= q_item.last;
                            // Last byte fills the block: padding goes in a fresh block.
                            second_reg <= q_item.last;
                            mark_reg   <= q_item.last;
                            total_reg  <= bits_reg + 64'd512;
                            bits_reg   <= bits_reg + 64'd512;
                            match_reg  <= q_item.last;
                        end
                        else if (q_item.last)
                        begin
                            final_reg  <= 1'b1;
                            mark_reg   <= 1'b1;
                            total_reg  <= bits_reg + {55'd0, fill_reg + 6'd1, 3'd0};
                            second_reg <= (fill_reg + 6'd1) >= 6'd56;
                            match_reg  <= 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    // First pad byte is the 0x80 marker, written at the fill point.
                    fill_reg <= fill_reg + 1'b1;
                    ld_reg   <= '0;
                    rnd_reg  <= '0;
                    mark_reg <= 1'b0;
                end
                ST_LOAD:
                begin
                    // Stream bytes out of the buffer into the word schedule, four to a word.
                    ld_reg <= ld_reg + 1'b1;
                    if (rnd_reg != 6'd0 || ld_reg != 6'd0)
                    begin
                        if (ld_reg[1:0] == 2'd1)
                        begin
                            for (int i = 0; i < 15; i++)
                            begin
                                w_reg[i] <= w_reg[i+1];
                            end
                            w_reg[15] <= {24'd0, buf_rd_reg};
                        end
                        else
                        begin
                            w_reg[15] <= {w_reg[15][23:0], buf_rd_reg};
                        end
                    end
                    if (ld_reg == 6'd0 && rnd_reg == 6'd1)
                    begin
                        rnd_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i];
                        end
                    end
                    else
                    begin
                        rnd_reg <= 6'd1;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    fill_reg   <= second_reg ? 6'd0 : fill_reg;
                    // The next pad block, if any, is the last and carries the length.
                    second_reg <= 1'b0;
                    oidx_reg   <= '0;
                    if (final_reg && !second_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        oword_reg  <= h_reg[0] + v_reg[0];
                        match_reg  <= (h_reg[0] + v_reg[0]) == expected[255:224];
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready && ovalid_reg)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            final_reg  <= 1'b0;
                            fill_reg   <= '0;
                            bits_reg   <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[i];
                            end
                        end
                        else
                        begin
                            oword_reg <= h_reg[3'(oidx_reg + 3'd1)];
                            match_reg <= match_reg
                                && (h_reg[3'(oidx_reg + 3'd1)]
                                    == expected[{3'd6 - oidx_reg, 5'd0} +: 32]);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = ovalid_reg;
    assign digest_word  = oword_reg;
    assign word_index   = oidx_reg;
    assign run_end      = (oidx_reg == 3'd7);
    assign digest_match = (oidx_reg == 3'd7) && match_reg;

endmodule

// ===== hdl/sha256_stream_hash_compare_unit.sv =====
// Top level: APB register file, byte queue front end and SHA-256 engine
//
//  channel  | handshake           | beat
//  in       | in_valid/in_ready   | data_byte, final_byte
//  out      | out_valid/out_ready | digest_word, word_index, run_end, digest_match
//  cfg      | psel/penable/pwrite | paddr, pwdata, prdata (64-bit registers)
//
// Bytes are buffered one at a time while the engine is idle; a full block then holds the
// engine for a load pass, 64 rounds and one add, and no byte leaves the queue meanwhile.
// The final byte adds padding over one or two blocks, one or two
// compressions and eight beats; each beat holds while out_ready is low.
// rst_n clears all control state and restores the initial hash; no clearing pass.
// The four-entry queue lets the front take beats while the engine compresses.
`include "sha256_stream_hash_compare_unit_defines.svh"
module sha256_stream_hash_compare_unit
    import shc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        run_end,
    output logic        digest_match,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] exp_reg [4];
    q_item_t     q_item;
    logic        q_valid, q_pop;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                exp_reg[i] <= '0;
            end
        end
        else if (wr_en && paddr[2:0] == 3'd0)
        begin
            case (widx)
                REG_EXP_W0: exp_reg[0] <= pwdata;
                REG_EXP_W1: exp_reg[1] <= pwdata;
                REG_EXP_W2: exp_reg[2] <= pwdata;
                REG_EXP_W3: exp_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    assign prdata = exp_reg[widx];

    shc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    shc_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .expected     ({exp_reg[0], exp_reg[1], exp_reg[2], exp_reg[3]}),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .run_end      (run_end),
        .digest_match (digest_match),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

    `SHC_ASSERT_NOW(a_match_only_at_end, digest_match, run_end)
    `SHC_ASSERT_NEXT(a_index_advances, out_valid && out_ready && !run_end,
                     out_valid && word_index == $past(word_index) + 3'd1)
    `SHC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                     out_valid && $stable(digest_word) && $stable(word_index))

endmodule
